// ===== hw/rtl/bpk_pkg.sv =====
// ----------------------------------------------------------------------------
// bpk_pkg
// Shared types, codes and helpers of the lsb-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpk_pkg;

  // operation codes of an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd32;
  localparam logic [COUNT_W-1:0] WIDTH_MIN = 6'd8;

  // classified item handed from the front to the back
  typedef struct packed {
    logic                 is_flush;
    logic [DATA_W-1:0]    value;
    logic [COUNT_W-1:0]   count;
  } bpk_item_t;

  // effective output width: at least 8, at most max_w, multiple of 8
  function automatic logic [COUNT_W-1:0] eff_width(input logic [COUNT_W-1:0] raw,
                                                   input logic [COUNT_W-1:0] max_w);
    logic [COUNT_W-1:0] w;
    w = raw;
    if (w < WIDTH_MIN) w = WIDTH_MIN;
    if (w > max_w) w = max_w;
    if (w > COUNT_MAX) w = COUNT_MAX;
    return w & 6'b111000;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpk_front.sv =====
// ----------------------------------------------------------------------------
// bpk_front
// Accepts input beats, clamps the bit count, classifies write and flush,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpk_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_operation,
  input  wire logic [31:0]                   in_value,
  input  wire logic [5:0]                    in_bit_count,
  output      logic                          q_valid,
  output      bpk_pkg::bpk_item_t            q_item,
  input  wire logic                          q_pop
);
  import bpk_pkg::*;

  bpk_item_t   mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  bpk_item_t   item_c;

  // classify the incoming beat
  always_comb begin
    item_c.is_flush = (in_operation == OP_FLUSH);
    item_c.value    = in_value;
    if (in_operation == OP_FLUSH) begin
      item_c.count = '0;
    end else if (in_bit_count > COUNT_MAX) begin
      item_c.count = COUNT_MAX;
    end else begin
      item_c.count = in_bit_count;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  // queue pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_c;
    end
  end

  // queue never overfills and pop only when something is queued
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd0 |=> count_r != 2'd3) else $error("queue underflow");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 && !q_pop |=> count_r == 2'd2) else $error("queue overfill");

endmodule

`default_nettype wire

// ===== hw/rtl/bpk_back.sv =====
// ----------------------------------------------------------------------------
// bpk_back
// Packing engine: merges one chunk per cycle into the accumulator while the
// output register can take a due word, and emits full or flushed words there.
// ----------------------------------------------------------------------------
`default_nettype none

module bpk_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [5:0]                    width,
  input  wire logic                          clear,
  input  wire logic                          q_valid,
  input  wire bpk_pkg::bpk_item_t            q_item,
  output      logic                          q_pop,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [31:0]                   out_word,
  output      logic                          out_last
);
  import bpk_pkg::*;

  logic [DATA_W-1:0]  acc_r, acc_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_word_r, out_word_nxt;
  logic               out_last_r, out_last_nxt;

  logic               has_item;
  logic               cur_flush;
  logic [DATA_W-1:0]  cur_val;
  logic [COUNT_W-1:0] cur_rem;
  logic [COUNT_W-1:0] room;
  logic [COUNT_W-1:0] take;
  logic [COUNT_W-1:0] rem_left;
  logic [DATA_W-1:0]  merged;
  logic [COUNT_W-1:0] new_fill;
  logic               full;
  logic               emit;
  logic               slot_free;
  logic               go;

  // current chunk comes from the working registers or the queue head
  assign has_item  = busy_r || q_valid;
  assign cur_flush = !busy_r && q_item.is_flush;
  assign cur_val   = busy_r ? val_r : q_item.value;
  assign cur_rem   = busy_r ? rem_r : q_item.count;

  // one chunk: as many bits as fit in the current word
  assign room     = width - fill_r;
  assign take     = (cur_rem < room) ? cur_rem : room;
  assign rem_left = cur_rem - take;
  assign merged   = acc_r | ((cur_val & ~({DATA_W{1'b1}} << take)) << fill_r);
  assign new_fill = fill_r + take;
  assign full     = (new_fill == width);

  assign emit      = cur_flush ? (fill_r != '0) : full;
  assign slot_free = !out_valid_r || out_ready;
  assign go        = has_item && (!emit || slot_free);
  assign q_pop     = go && !busy_r;

  // engine next state
  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    busy_nxt = busy_r;
    if (clear) begin
      acc_nxt  = '0;
      fill_nxt = '0;
      busy_nxt = 1'b0;
    end else if (go) begin
      if (cur_flush || full) begin
        acc_nxt  = '0;
        fill_nxt = '0;
      end else begin
        acc_nxt  = merged;
        fill_nxt = new_fill;
      end
      val_nxt  = cur_val >> take;
      rem_nxt  = cur_flush ? '0 : rem_left;
      busy_nxt = !cur_flush && (rem_left != '0);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    if (go && emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = cur_flush ? acc_r : merged;
      out_last_nxt  = cur_flush || (rem_left < width);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  // pending bits always stay below one word
  a_fill_below: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < width) else $error("fill level reached word width");
  // accumulator is zero above the fill position
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> fill_r) == '0) else $error("stray bits above fill level");
  // a busy engine always has bits left to place
  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != '0) else $error("busy with nothing left");
  // emitted word has nothing above the configured width
  a_word_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r >> width) == '0 || width == COUNT_MAX)
    else $error("output word wider than configured");

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_first_bit_packer.sv =====
// An accepted beat enters the queue, and its first word goes to the output
// register when the engine and the output register are free. The engine places
// one chunk per cycle while the output register can take a due word: one per
// word a write fills, plus one for leftover bits, or one for a flush. A
// two-entry queue lets input beats be taken while the engine is busy. Reset
// (rst_n, synchronous, active low) clears the queue, accumulator and fill level
// and sets width to MAX_WORD_BITS cut to bytes; writing it drops pending bits.
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-width codes lsb-first into 8/16/24/32-bit output words.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_first_bit_packer #(
  parameter int unsigned MAX_WORD_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_write_en,
  input  wire logic [5:0]   cfg_write_data,
  input  wire logic         in_valid,
  output      logic         in_ready,
  input  wire logic         in_operation,
  input  wire logic [31:0]  in_value,
  input  wire logic [5:0]   in_bit_count,
  output      logic         out_valid,
  input  wire logic         out_ready,
  output      logic [31:0]  out_word,
  output      logic         out_last
);
  import bpk_pkg::*;

  localparam logic [COUNT_W-1:0] MaxW = COUNT_W'(MAX_WORD_BITS);

  logic [COUNT_W-1:0] width_r, width_nxt;
  logic               q_valid;
  bpk_item_t          q_item;
  logic               q_pop;

  // word width register, stored already rounded
  assign width_nxt = cfg_write_en ? eff_width(cfg_write_data, MaxW) : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= eff_width(COUNT_MAX, MaxW);
    end else begin
      width_r <= width_nxt;
    end
  end

  // front: accept and classify beats
  bpk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_bit_count (in_bit_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: pack and emit words
  bpk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .width     (width_r),
    .clear     (cfg_write_en),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lsb-first bit packer. Write and flush beats go
// through a valid/ready driver. A small scoreboard predicts the packed words
// and their last flags for every accepted beat and compares them in order
// with the output beats. Word width changes between phases, while the block
// is idle. Both sides pause at random, and two long output hold-offs fill the
// block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bpk_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned SETTLE_TICKS = 30;
  localparam int unsigned HOLD_TICKS   = 200;
  localparam int unsigned PHASE_BEATS  = 40;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } packed_word_t;

  // predicts packed words and keeps those still due from the block
  class word_scoreboard;
    packed_word_t due_words[$];
    logic [31:0]  acc_bits;
    int unsigned  fill_bits;
    int unsigned  width_bits;
    int unsigned  mismatches;

    function new();
      acc_bits   = '0;
      fill_bits  = 0;
      width_bits = 32;
      mismatches = 0;
    endfunction

    // out-of-range widths are clamped and rounded down to whole bytes
    function void set_width(logic [5:0] raw);
      int unsigned w;
      w = raw;
      if (w < 8) w = 8;
      if (w > 32) w = 32;
      width_bits = w & ~7;
      acc_bits   = '0;
      fill_bits  = 0;
    endfunction

    function void note_beat(logic op, logic [31:0] val, logic [5:0] cnt);
      packed_word_t pw;
      logic [63:0]  rest;
      logic [63:0]  merged;
      int unsigned  left;
      int unsigned  take;
      int unsigned  emitted;
      emitted = 0;
      // flush: partial word goes out only when bits are pending
      if (op == OP_FLUSH) begin
        if (fill_bits != 0) begin
          pw.word = acc_bits;
          pw.last = 1'b1;
          due_words.push_back(pw);
        end
        acc_bits  = '0;
        fill_bits = 0;
        return;
      end
      // write: counts above 32 act as 32
      rest = {32'd0, val};
      left = (cnt > 6'd32) ? 32 : cnt;
      while (left > 0) begin
        take   = (left < width_bits - fill_bits) ? left : width_bits - fill_bits;
        merged = {32'd0, acc_bits} | ((rest & ((64'd1 << take) - 64'd1)) << fill_bits);
        acc_bits  = merged[31:0] & 32'((64'd1 << width_bits) - 64'd1);
        rest      = rest >> take;
        left      = left - take;
        fill_bits = fill_bits + take;
        if (fill_bits == width_bits) begin
          pw.word = acc_bits;
          pw.last = 1'b0;
          due_words.push_back(pw);
          emitted++;
          acc_bits  = '0;
          fill_bits = 0;
        end
      end
      if (emitted > 0) due_words[due_words.size()-1].last = 1'b1;
    endfunction

    function void check_word(logic [31:0] word, logic last);
      packed_word_t pw;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual word %h last %b",
                 $time, word, last);
        mismatches++;
        return;
      end
      pw = due_words.pop_front();
      if (word !== pw.word) begin
        $display("%0t: word mismatch, expected %h actual %h", $time, pw.word, word);
        mismatches++;
      end
      if (last !== pw.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, pw.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return due_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_write_en;
  logic [5:0]  cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_value;
  logic [5:0]  in_bit_count;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_word;
  logic        out_last;

  word_scoreboard board = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned quiet_ticks;

  lsb_first_bit_packer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .out_last       (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_TICKS) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result beats against the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_word(out_word, out_last);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_ticks = 0;
    end else begin
      quiet_ticks = quiet_ticks + 1;
      if (quiet_ticks >= QUIET_LIMIT) begin
        $display("%0t: timeout with %0d words still due", $time, board.outstanding());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one input beat, with random gaps before it
  task automatic send_beat(input logic op, input logic [31:0] val, input logic [5:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_bit_count <= cnt;
    do @(posedge clk); while (!in_ready);
    board.note_beat(op, val, cnt);
  endtask

  // mostly writes of 1..32 bits, some clamped or empty writes, some flushes
  task automatic send_random_beat();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) send_beat(OP_FLUSH, $urandom(), 6'($urandom_range(63)));
    else if (roll < 20) send_beat(OP_WRITE, $urandom(), 6'($urandom_range(63, 33)));
    else if (roll < 25) send_beat(OP_WRITE, $urandom(), 6'd0);
    else send_beat(OP_WRITE, $urandom(), 6'($urandom_range(32, 1)));
  endtask

  // stop offering, collect every due word, then let the engine settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_width(input logic [5:0] raw);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= raw;
    @(posedge clk);
    board.set_width(raw);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [5:0] phase_widths[8];
    phase_widths = '{6'd8, 6'd63, 6'd16, 6'd0, 6'd24, 6'd13, 6'd45, 6'd32};
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    in_operation   = OP_WRITE;
    in_value       = '0;
    in_bit_count   = '0;
    hold_request   = 1'b0;
    quiet_ticks    = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 78;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats at the reset width of 32
    send_beat(OP_FLUSH, 32'hffff_ffff, 6'd63);   // nothing pending
    send_beat(OP_WRITE, 32'hffff_ffff, 6'd0);    // empty write
    send_beat(OP_WRITE, 32'h0000_0001, 6'd1);
    send_beat(OP_FLUSH, 32'h0000_0000, 6'd0);
    send_beat(OP_WRITE, 32'hffff_ffff, 6'd32);   // exactly one word
    send_beat(OP_WRITE, 32'haaaa_aaaa, 6'd63);   // clamped count
    send_beat(OP_WRITE, 32'h0000_0005, 6'd3);
    send_beat(OP_WRITE, 32'hffff_ffff, 6'd32);   // straddles two words
    send_beat(OP_WRITE, 32'h0000_0000, 6'd33);
    send_beat(OP_FLUSH, 32'h5555_5555, 6'd17);
    send_beat(OP_FLUSH, 32'hffff_ffff, 6'd32);   // back-to-back flush
    send_beat(OP_WRITE, 32'h1234_5678, 6'd31);
    send_beat(OP_WRITE, 32'hffff_ffff, 6'd1);
    send_beat(OP_WRITE, 32'h0000_0000, 6'd32);
    send_beat(OP_WRITE, 32'hdead_beef, 6'd16);
    send_beat(OP_WRITE, 32'hffff_ffff, 6'd40);
    send_beat(OP_FLUSH, 32'h0000_0000, 6'd0);
    send_beat(OP_WRITE, 32'h8000_0001, 6'd20);   // left pending across width change

    // random phases, one width each; pending bits are dropped at each change
    foreach (phase_widths[p]) begin
      drain();
      write_width(phase_widths[p]);
      if (p < 3) begin
        send_idle_pct  = 10;
        recv_stall_pct = 78;
      end else if (p < 6) begin
        send_idle_pct  = 78;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // four words from one beat at byte width
      if (p == 0) begin
        send_beat(OP_WRITE, 32'h0000_007f, 6'd7);
        send_beat(OP_WRITE, 32'hffff_ffff, 6'd32);
        send_beat(OP_FLUSH, 32'h0000_0000, 6'd0);
      end
      if (p == 1 || p == 6) hold_request = 1'b1;
      repeat (PHASE_BEATS) send_random_beat();
    end
    drain();

    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
